[rtl/grt_pkg.sv]
// Package: shared constants and types for the grid ray traversal block.
package grt_pkg;
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;
    localparam int CNT_W = 9;
    localparam int CRD_W = 10;
    localparam int DST_W = 43;
    localparam logic [31:0] STEP_MAX = 32'hFFFF_FFFF;
    localparam logic [23:0] DIST_MAX = 24'hFF_FFFF;
    typedef enum logic [0:0] {REG_COLS = 1'b0, REG_ROWS = 1'b1} t_reg_idx;
    typedef enum logic [0:0] {OP_CAST = 1'b0, OP_WRITE = 1'b1} t_op;
endpackage

[rtl/grid_ray_traversal.sv]
// Top level: grid ray traversal over a tile map held in one synchronous memory.
// After reset the block sweeps all MAX_COLS*MAX_ROWS entries of the tile memory
// to zero, one entry a cycle, and takes no request during the sweep. A cell write
// is done as it is accepted. A cast finds the two reciprocals in one shared
// restoring divider, then the start distances, then steps the grid with one
// memory read per step, and then hands over the result.
module grid_ray_traversal #(
    parameter int MAX_COLS = grt_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = grt_pkg::DEF_MAX_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [21:0]        i_start_x,
    input  logic [21:0]        i_start_y,
    input  logic signed [17:0] i_dir_x,
    input  logic signed [17:0] i_dir_y,
    input  logic [5:0]         i_cell_col,
    input  logic [5:0]         i_cell_row,
    input  logic signed [7:0]  i_cell_tile,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [23:0]        o_distance,
    output logic               o_wall_side,
    output logic [5:0]         o_hit_col,
    output logic [5:0]         o_hit_row,
    output logic               o_no_hit
);
    import grt_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MULX, S_MULY, S_STEP, S_LOOK, S_DONE} t_state;

    t_state r_state;
    logic [6:0] r_cols, r_rows;
    logic [CNT_W-1:0] cols, rows;
    logic r_clearing;
    logic [ADDR_W-1:0] r_clr;
    logic [7:0] mem [DEPTH];
    logic [7:0] r_rd;
    logic we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [7:0] wdata;

    logic [15:0] r_fx, r_fy;
    logic r_negx, r_negy, r_axis;
    logic [17:0] r_magx, r_magy;
    logic [18:0] r_rem;
    logic [32:0] r_q;
    logic [5:0] r_cnt;
    logic [31:0] r_dx, r_dy;
    logic [DST_W-1:0] r_distx, r_disty, r_dist;
    logic signed [CRD_W-1:0] r_cx, r_cy;
    logic r_side;
    logic r_miss;

    logic r_ov;
    logic [23:0] r_odist;
    logic r_oside, r_onohit;
    logic [5:0] r_ocol, r_orow;

    logic in_acc;
    logic [17:0] dmag, magx_in, magy_in;
    logic [18:0] rem_sh, rem_sub;
    logic ge;
    logic [31:0] step_val;
    logic [16:0] f_mul;
    logic [31:0] d_mul;
    logic [48:0] prod;
    logic take_x;
    logic signed [CRD_W-1:0] nx, ny;
    logic out_of_map;
    logic [19:0] rd_full, wr_full;

    assign cols = (r_cols > 7'(MAX_COLS > 127 ? 127 : MAX_COLS)) && (MAX_COLS < 128)
                  ? CNT_W'(MAX_COLS) : CNT_W'(r_cols);
    assign rows = (r_rows > 7'(MAX_ROWS > 127 ? 127 : MAX_ROWS)) && (MAX_ROWS < 128)
                  ? CNT_W'(MAX_ROWS) : CNT_W'(r_rows);

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && !r_clearing;
    assign in_acc      = i_in_valid && o_in_ready;

    assign magx_in = i_dir_x[17] ? 18'(-i_dir_x) : 18'(i_dir_x);
    assign magy_in = i_dir_y[17] ? 18'(-i_dir_y) : 18'(i_dir_y);

    assign dmag    = r_axis ? r_magy : r_magx;
    assign rem_sh  = {r_rem[17:0], (r_cnt == 6'd32)};
    assign ge      = rem_sh >= {1'b0, dmag};
    assign rem_sub = ge ? rem_sh - {1'b0, dmag} : rem_sh;
    assign step_val = (dmag == 18'd0 || r_q[31]) ? STEP_MAX : {r_q[30:0], ge};

    assign f_mul = (r_state == S_MULX)
                   ? (r_negx ? {1'b0, r_fx} : 17'h10000 - {1'b0, r_fx})
                   : (r_negy ? {1'b0, r_fy} : 17'h10000 - {1'b0, r_fy});
    assign d_mul = (r_state == S_MULX) ? r_dx : r_dy;
    assign prod  = f_mul * d_mul;

    assign take_x = r_distx < r_disty;
    assign nx = take_x ? (r_negx ? r_cx - CRD_W'(1) : r_cx + CRD_W'(1)) : r_cx;
    assign ny = take_x ? r_cy : (r_negy ? r_cy - CRD_W'(1) : r_cy + CRD_W'(1));
    assign out_of_map = nx[CRD_W-1] || ny[CRD_W-1]
                        || (nx >= $signed({1'b0, cols})) || (ny >= $signed({1'b0, rows}));

    assign rd_full = 20'(ny[CNT_W-1:0]) * 20'(cols) + 20'(nx[CNT_W-1:0]);
    assign wr_full = 20'(i_cell_row) * 20'(cols) + 20'(i_cell_col);
    assign raddr   = rd_full[ADDR_W-1:0];

    always_comb begin
        we    = 1'b0;
        waddr = wr_full[ADDR_W-1:0];
        wdata = i_cell_tile;
        if (r_clearing) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = 8'd0;
        end else if (in_acc && i_operation == OP_WRITE
                     && CNT_W'(i_cell_col) < cols && CNT_W'(i_cell_row) < rows) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cols     <= 7'd64;
            r_rows     <= 7'd64;
            r_clearing <= 1'b1;
            r_clr      <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_COLS: r_cols <= i_cfg_data;
                    REG_ROWS: r_rows <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_clearing) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (r_state == S_DONE && (!r_ov || i_out_ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_operation == OP_CAST) begin
                        r_fx    <= i_start_x[15:0];
                        r_fy    <= i_start_y[15:0];
                        r_cx    <= CRD_W'(i_start_x[21:16]);
                        r_cy    <= CRD_W'(i_start_y[21:16]);
                        r_negx  <= i_dir_x[17];
                        r_negy  <= i_dir_y[17];
                        r_magx  <= magx_in;
                        r_magy  <= magy_in;
                        r_axis  <= 1'b0;
                        r_cnt   <= 6'd32;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 6'd0) begin
                        r_cnt <= 6'd32;
                        r_rem <= '0;
                        r_q   <= '0;
                        if (!r_axis) begin
                            r_dx   <= step_val;
                            r_axis <= 1'b1;
                        end else begin
                            r_dy    <= step_val;
                            r_state <= S_MULX;
                        end
                    end else begin
                        r_rem <= rem_sub;
                        r_q   <= {r_q[31:0], ge};
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_MULX: begin
                    r_distx <= DST_W'(prod[48:16]);
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_disty <= DST_W'(prod[48:16]);
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (take_x) begin
                        r_dist  <= r_distx;
                        r_distx <= r_distx + DST_W'(r_dx);
                        r_side  <= 1'b0;
                    end else begin
                        r_dist  <= r_disty;
                        r_disty <= r_disty + DST_W'(r_dy);
                        r_side  <= 1'b1;
                    end
                    r_cx   <= nx;
                    r_cy   <= ny;
                    r_miss <= out_of_map;
                    r_state <= out_of_map ? S_DONE : S_LOOK;
                end
                S_LOOK: begin
                    r_state <= (!r_rd[7] && r_rd != 8'd0) ? S_DONE : S_STEP;
                end
                S_DONE: begin
                    if (!r_ov || i_out_ready) begin
                        r_onohit <= r_miss;
                        r_odist  <= r_miss ? 24'd0
                                   : (r_dist > DST_W'(DIST_MAX) ? DIST_MAX : r_dist[23:0]);
                        r_oside  <= r_miss ? 1'b0 : r_side;
                        r_ocol   <= r_miss ? 6'd0 : r_cx[5:0];
                        r_orow   <= r_miss ? 6'd0 : r_cy[5:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_distance  = r_odist;
    assign o_wall_side = r_oside;
    assign o_hit_col   = r_ocol;
    assign o_hit_row   = r_orow;
    assign o_no_hit    = r_onohit;
endmodule

[bench/tb_grid_ray_traversal.sv]
// Self-checking testbench for the grid ray traversal block: map writes, casts and map size settings.
module tb_grid_ray_traversal;
    timeunit 1ns;
    timeprecision 1ps;
    import grt_pkg::*;

    typedef struct packed {
        logic [23:0] distance;
        logic        wall_side;
        logic [5:0]  hit_col;
        logic [5:0]  hit_row;
        logic        no_hit;
    } t_hit;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = 1'b0;
    logic [6:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_operation = 1'b0;
    logic [21:0]        i_start_x = '0;
    logic [21:0]        i_start_y = '0;
    logic signed [17:0] i_dir_x = '0;
    logic signed [17:0] i_dir_y = '0;
    logic [5:0]         i_cell_col = '0;
    logic [5:0]         i_cell_row = '0;
    logic signed [7:0]  i_cell_tile = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [23:0]        o_distance;
    logic               o_wall_side;
    logic [5:0]         o_hit_col;
    logic [5:0]         o_hit_row;
    logic               o_no_hit;

    grid_ray_traversal dut (.*);

    always #4 i_clk = ~i_clk;

    logic [6:0] cols_reg;
    logic [6:0] rows_reg;
    logic [7:0] tiles [DEF_MAX_COLS*DEF_MAX_ROWS];
    t_hit       pending_hits [$];
    int         n_mismatch = 0;
    int         n_hits = 0;
    int         n_casts = 0;
    int         n_writes = 0;
    int         n_walls = 0;
    int         burst_left = 0;
    bit         stall_mode = 1'b0;

    function automatic logic [31:0] step_of(logic signed [17:0] d);
        logic [17:0] m;
        logic [32:0] q;
        m = d[17] ? 18'(-d) : 18'(d);
        if (m == 0) return STEP_MAX;
        q = 33'h1_0000_0000 / m;
        return q > {1'b0, STEP_MAX} ? STEP_MAX : q[31:0];
    endfunction

    function automatic int unsigned eff(logic [6:0] v, int lim);
        return v > lim ? lim : v;
    endfunction

    function automatic t_hit cast_ray(logic [21:0] sx, logic [21:0] sy,
                                      logic signed [17:0] dx_in, logic signed [17:0] dy_in);
        t_hit r;
        int unsigned cols, rows;
        logic [63:0] dx, dy, sdx, sdy, d;
        int cx, cy, stx, sty;
        logic side;
        logic [7:0] t;
        cols = eff(cols_reg, DEF_MAX_COLS);
        rows = eff(rows_reg, DEF_MAX_ROWS);
        dx = step_of(dx_in);
        dy = step_of(dy_in);
        cx = sx[21:16];
        cy = sy[21:16];
        sdx = ((dx_in[17] ? 64'(sx[15:0]) : 64'(65536 - sx[15:0])) * dx) >> 16;
        sdy = ((dy_in[17] ? 64'(sy[15:0]) : 64'(65536 - sy[15:0])) * dy) >> 16;
        stx = dx_in[17] ? -1 : 1;
        sty = dy_in[17] ? -1 : 1;
        r = '0;
        forever begin
            if (sdx < sdy) begin
                d = sdx; sdx += dx; cx += stx; side = 1'b0;
            end else begin
                d = sdy; sdy += dy; cy += sty; side = 1'b1;
            end
            if (cx < 0 || cy < 0 || cx >= cols || cy >= rows) begin
                r.no_hit = 1'b1;
                return r;
            end
            t = tiles[cy*cols + cx];
            if (t >= 1 && t <= 127) break;
        end
        r.distance = d > 64'(DIST_MAX) ? DIST_MAX : d[23:0];
        r.wall_side = side;
        r.hit_col = 6'(cx);
        r.hit_row = 6'(cy);
        return r;
    endfunction

    task automatic send_request(t_op op, logic [21:0] sx, logic [21:0] sy,
                                logic signed [17:0] dx, logic signed [17:0] dy,
                                logic [5:0] col, logic [5:0] row, logic [7:0] tile);
        int unsigned cols, rows;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
        burst_left--;
        i_operation <= op;
        i_start_x <= sx; i_start_y <= sy; i_dir_x <= dx; i_dir_y <= dy;
        i_cell_col <= col; i_cell_row <= row; i_cell_tile <= tile;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_WRITE) begin
            cols = eff(cols_reg, DEF_MAX_COLS);
            rows = eff(rows_reg, DEF_MAX_ROWS);
            if (col < cols && row < rows) tiles[row*cols + col] = tile;
            n_writes++;
        end else begin
            pending_hits.push_back(cast_ray(sx, sy, dx, dy));
            n_casts++;
        end
        @(negedge i_clk);
    endtask

    task automatic write_cell(logic [5:0] col, logic [5:0] row, logic [7:0] tile);
        send_request(OP_WRITE, '0, '0, '0, '0, col, row, tile);
    endtask

    task automatic cast(logic [21:0] sx, logic [21:0] sy,
                        logic signed [17:0] dx, logic signed [17:0] dy);
        send_request(OP_CAST, sx, sy, dx, dy, '0, '0, '0);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_hits.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_reg(t_reg_idx idx, logic [6:0] v);
        drain();
        i_cfg_index <= idx;
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_COLS) cols_reg = v; else rows_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_cast;
        logic signed [17:0] dx, dy;
        dx = 18'($urandom);
        dy = 18'($urandom);
        case ($urandom_range(0, 5))
            0: dx = '0;
            1: dy = '0;
            2: dx = 18'($urandom_range(0, 3)) - 18'sd1;
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0)
            cast(22'($urandom), 22'($urandom), dx, dy);
        else
            cast({6'($urandom_range(0, eff(cols_reg, DEF_MAX_COLS))), 16'($urandom)},
                 {6'($urandom_range(0, eff(rows_reg, DEF_MAX_ROWS))), 16'($urandom)},
                 dx, dy);
    endtask

    task automatic random_write;
        logic [7:0] tile;
        tile = $urandom_range(0, 2) == 0 ? 8'($urandom) : 8'($urandom_range(1, 127));
        if ($urandom_range(0, 9) == 0)
            write_cell(6'($urandom), 6'($urandom), tile);
        else
            write_cell(6'($urandom_range(0, eff(cols_reg, DEF_MAX_COLS) - 1)),
                       6'($urandom_range(0, eff(rows_reg, DEF_MAX_ROWS) - 1)), tile);
    endtask

    task automatic test_empty_map;
        cast({6'd10, 16'h8000}, {6'd10, 16'h8000}, 18'sd65536, 18'sd0);
        cast({6'd63, 16'hFFFF}, {6'd63, 16'hFFFF}, 18'sd131071, -18'sd131072);
        cast(22'h3FFFFF, 22'h3FFFFF, -18'sd131072, -18'sd1);
        cast('0, '0, 18'sd0, 18'sd0);
    endtask

    task automatic test_directed_walls;
        write_cell(6'd12, 6'd10, 8'sd1);
        write_cell(6'd10, 6'd12, 8'sd127);
        write_cell(6'd8, 6'd10, -8'sd128);
        write_cell(6'd5, 6'd10, 8'sd5);
        write_cell(6'd63, 6'd63, 8'sd9);
        write_cell(6'd10, 6'd10, 8'sd3);
        cast({6'd10, 16'h8000}, {6'd10, 16'h8000}, 18'sd65536, 18'sd0);
        cast({6'd10, 16'h0000}, {6'd10, 16'h4000}, 18'sd0, 18'sd65536);
        cast({6'd10, 16'hFFFF}, {6'd10, 16'h0001}, -18'sd65536, 18'sd0);
        cast({6'd10, 16'h8000}, {6'd10, 16'h8000}, 18'sd1, 18'sd0);
        cast({6'd60, 16'h0}, {6'd60, 16'h0}, 18'sd131071, 18'sd131071);
        cast({6'd10, 16'h8000}, {6'd10, 16'h8000}, 18'sd1, -18'sd1);
        write_cell(6'd63, 6'd63, 8'sd0);
    endtask

    task automatic test_map_sizes;
        set_reg(REG_COLS, 7'd0);
        cast({6'd0, 16'h8000}, {6'd0, 16'h8000}, 18'sd1000, 18'sd3000);
        write_cell(6'd0, 6'd0, 8'sd1);
        set_reg(REG_COLS, 7'd127);
        set_reg(REG_ROWS, 7'd127);
        cast({6'd10, 16'h8000}, {6'd10, 16'h8000}, 18'sd65536, 18'sd0);
        set_reg(REG_ROWS, 7'd0);
        cast({6'd1, 16'h0}, {6'd1, 16'h0}, -18'sd100, 18'sd100);
        set_reg(REG_COLS, 7'd70);
        set_reg(REG_ROWS, 7'd1);
        cast({6'd2, 16'h0}, {6'd0, 16'h8000}, 18'sd50000, 18'sd0);
    endtask

    task automatic test_random_phase(int items, logic [6:0] c, logic [6:0] r);
        set_reg(REG_COLS, c);
        set_reg(REG_ROWS, r);
        repeat (items) begin
            if ($urandom_range(0, 99) < 35) random_write();
            else random_cast();
        end
    endtask

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
        i_out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    always @(posedge i_clk) begin
        t_hit got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_distance, o_wall_side, o_hit_col, o_hit_row, o_no_hit};
            n_hits++;
            if (pending_hits.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %p", got);
            end else begin
                want = pending_hits.pop_front();
                if (!want.no_hit && got.no_hit == 1'b0) n_walls++;
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        cols_reg = 7'd64;
        rows_reg = 7'd64;
        foreach (tiles[k]) tiles[k] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_map();
        test_directed_walls();
        test_map_sizes();
        test_random_phase(250, 7'd8, 7'd8);
        test_random_phase(200, 7'd64, 7'd64);
        test_random_phase(150, 7'd1, 7'd64);
        test_random_phase(150, 7'd37, 7'd5);
        drain();
        $display("run covered %0d casts (%0d wall hits) and %0d cell writes",
                 n_casts, n_walls, n_writes);
        $display("over several map sizes, with input gaps and output stalls");
        if (n_mismatch == 0 && pending_hits.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", n_mismatch, pending_hits.size());
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
